FILE: hdl/lruk_pkg.sv
// Shared types and constants for the LRU-K replacement block.
// No dependencies; imported by lruk_queue and lru_k_replacement.
package lruk_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF    = 15;

    localparam int HIT_BITS       = 8;
    localparam int THRESH_BITS    = 8;
    localparam int CAP_BITS       = 5;
    localparam int CFG_DATA_BITS  = 8;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = 8'd2;
    localparam logic [CAP_BITS-1:0]    CAP_RESET    = 5'd16;
    localparam logic [HIT_BITS-1:0]    HIT_MAX      = 8'hFF;
    localparam logic [HIT_BITS-1:0]    HIT_FIRST    = 8'd1;

    localparam logic SRC_CACHE   = 1'b0;
    localparam logic SRC_HISTORY = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_CAPACITY  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        OUT_CACHE_HIT  = 3'd0,
        OUT_HIST_HIT   = 3'd1,
        OUT_PROMOTE    = 3'd2,
        OUT_MISS_HIST  = 3'd3,
        OUT_MISS_CACHE = 3'd4
    } outcome_t;

    // Update request for one queue: remove an entry, then append at the tail
    typedef struct packed {
        logic remove;
        logic append;
    } queue_op_t;

endpackage

FILE: hdl/lruk_queue.sv
// Ordered key queue held in a row of registers: parallel search, remove with
// shift-down compaction and tail append, applied together. Depends on lruk_pkg.
module lruk_queue import lruk_pkg::*; #(
    parameter int DEPTH   = QUEUE_DEPTH_DEF,
    parameter int KEY_W   = KEY_BITS_DEF,
    parameter int ENTRY_W = KEY_BITS_DEF,
    localparam int CW     = $clog2(DEPTH + 1),
    localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [KEY_W-1:0]   find_key,
    output logic               hit,
    output logic [IW-1:0]      hit_idx,
    output logic [ENTRY_W-1:0] hit_entry,
    output logic [ENTRY_W-1:0] head_entry,
    output logic [CW-1:0]      count,
    output logic [CW-1:0]      count_next,
    input  queue_op_t          op,
    input  logic [IW-1:0]      remove_idx,
    input  logic [ENTRY_W-1:0] append_entry
);

    logic [ENTRY_W-1:0] entry_reg  [DEPTH];
    logic [ENTRY_W-1:0] entry_next [DEPTH];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      removed_count;
    logic [DEPTH-1:0]   match;

    // Keys are unique within a queue, so OR the matching lanes together
    always_comb begin
        hit_idx   = '0;
        hit_entry = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (CW'(i) < count_reg) && (entry_reg[i][KEY_W-1:0] == find_key);
            if (match[i]) begin
                hit_idx   = hit_idx | IW'(i);
                hit_entry = hit_entry | entry_reg[i];
            end
        end
        hit = |match;
    end

    always_comb begin
        int src;
        removed_count = count_reg - CW'(op.remove);
        for (int i = 0; i < DEPTH; i++) begin
            src = (i == DEPTH - 1) ? i : i + 1;
            if (op.remove && (IW'(i) >= remove_idx)) begin
                entry_next[i] = entry_reg[src];
            end else begin
                entry_next[i] = entry_reg[i];
            end
            if (op.append && (CW'(i) == removed_count)) begin
                entry_next[i] = append_entry;
            end
        end
        count_next = removed_count
                   + CW'(op.append && (removed_count < CW'(DEPTH)));
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign head_entry = entry_reg[0];
    assign count      = count_reg;

endmodule

FILE: hdl/lru_k_replacement.sv
// LRU-K replacement top level: input register, decision logic, result register.
// Depends on lruk_pkg and lruk_queue.
//
// Each accepted key is looked up in the cache queue, then in the history
// queue, and the item's outcome, any head eviction and both fill levels come
// back as one result item. The block takes one item per clock cycle while
// results are taken (m_ready high). An accepted item moves from the input
// register into the result register, where its result is presented; it waits
// in the input register while an untaken result holds the result register.
// Each queue's parallel key search and shift-down compaction take a single
// pass, and queue state updates on the same edge that loads the result. Both
// queues are empty after reset and usable at once. Write promote_threshold
// (index 0) and queue_capacity (index 1) only while no item is in flight.
module lru_k_replacement import lruk_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1),
    localparam int IW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [KEY_BITS-1:0]       s_access_key,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_outcome,
    output logic                      m_evict_valid,
    output logic                      m_evict_source,
    output logic [KEY_BITS-1:0]       m_evicted_key,
    output logic [CW-1:0]             m_cache_fill,
    output logic [CW-1:0]             m_history_fill
);

    localparam int HIST_W = KEY_BITS + HIT_BITS;

    logic [THRESH_BITS-1:0] threshold_reg;
    logic [CAP_BITS-1:0]    capacity_reg;

    logic                in_valid_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                advance;

    logic                out_valid_reg;
    outcome_t            outcome_reg, outcome_next;
    logic                evict_valid_reg, evict_valid_next;
    logic                evict_source_reg, evict_source_next;
    logic [KEY_BITS-1:0] evicted_key_reg, evicted_key_next;
    logic [CW-1:0]       cache_fill_reg, history_fill_reg;

    logic [CW-1:0]          cap_eff;
    logic [THRESH_BITS-1:0] k_eff;

    logic                c_hit, h_hit;
    logic [IW-1:0]       c_hit_idx, h_hit_idx;
    logic [KEY_BITS-1:0] c_head;
    logic [HIST_W-1:0]   h_hit_entry, h_head;
    logic [CW-1:0]       c_count, c_count_next, h_count, h_count_next;
    queue_op_t           c_op, h_op, c_op_gated, h_op_gated;
    logic [IW-1:0]       c_remove_idx, h_remove_idx;
    logic [HIT_BITS-1:0] hits_old, hits_inc, hits_append;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESH_RESET;
            capacity_reg  <= CAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: threshold_reg <= cfg_wdata[THRESH_BITS-1:0];
                CFG_CAPACITY:  capacity_reg  <= cfg_wdata[CAP_BITS-1:0];
            endcase
        end
    end

    // Input register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg <= s_access_key;
        end
    end

    lruk_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .KEY_W   (KEY_BITS),
        .ENTRY_W (KEY_BITS)
    ) u_cache (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .find_key     (key_reg),
        .hit          (c_hit),
        .hit_idx      (c_hit_idx),
        .hit_entry    (),
        .head_entry   (c_head),
        .count        (c_count),
        .count_next   (c_count_next),
        .op           (c_op_gated),
        .remove_idx   (c_remove_idx),
        .append_entry (key_reg)
    );

    lruk_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .KEY_W   (KEY_BITS),
        .ENTRY_W (HIST_W)
    ) u_history (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .find_key     (key_reg),
        .hit          (h_hit),
        .hit_idx      (h_hit_idx),
        .hit_entry    (h_hit_entry),
        .head_entry   (h_head),
        .count        (h_count),
        .count_next   (h_count_next),
        .op           (h_op_gated),
        .remove_idx   (h_remove_idx),
        .append_entry ({hits_append, key_reg})
    );

    // Clamp capacity to 1..QUEUE_DEPTH and treat a threshold of zero as one
    always_comb begin
        if (capacity_reg == '0) begin
            cap_eff = CW'(1);
        end else if (32'(capacity_reg) > QUEUE_DEPTH) begin
            cap_eff = CW'(QUEUE_DEPTH);
        end else begin
            cap_eff = CW'(capacity_reg);
        end
        k_eff = (threshold_reg == '0) ? THRESH_BITS'(1) : threshold_reg;
    end

    assign hits_old = h_hit_entry[HIST_W-1 -: HIT_BITS];
    assign hits_inc = (hits_old == HIT_MAX) ? HIT_MAX : hits_old + HIT_BITS'(1);

    always_comb begin
        c_op              = '0;
        h_op              = '0;
        c_remove_idx      = '0;
        h_remove_idx      = '0;
        hits_append       = HIT_FIRST;
        evict_valid_next  = 1'b0;
        evict_source_next = SRC_CACHE;
        evicted_key_next  = '0;
        if (c_hit) begin
            c_op.remove  = 1'b1;
            c_op.append  = 1'b1;
            c_remove_idx = c_hit_idx;
            outcome_next = OUT_CACHE_HIT;
        end else if (h_hit) begin
            h_op.remove  = 1'b1;
            h_remove_idx = h_hit_idx;
            if (hits_inc >= k_eff) begin
                // Promote: make room at the cache head if full
                if (c_count >= cap_eff) begin
                    c_op.remove      = 1'b1;
                    evict_valid_next = 1'b1;
                    evicted_key_next = c_head;
                end
                c_op.append  = 1'b1;
                outcome_next = OUT_PROMOTE;
            end else begin
                h_op.append  = 1'b1;
                hits_append  = hits_inc;
                outcome_next = OUT_HIST_HIT;
            end
        end else if (k_eff == THRESH_BITS'(1)) begin
            if (c_count >= cap_eff) begin
                c_op.remove      = 1'b1;
                evict_valid_next = 1'b1;
                evicted_key_next = c_head;
            end
            c_op.append  = 1'b1;
            outcome_next = OUT_MISS_CACHE;
        end else begin
            if (h_count >= cap_eff) begin
                h_op.remove       = 1'b1;
                evict_valid_next  = 1'b1;
                evict_source_next = SRC_HISTORY;
                evicted_key_next  = h_head[KEY_BITS-1:0];
            end
            h_op.append  = 1'b1;
            outcome_next = OUT_MISS_HIST;
        end
    end

    // Hold queue state unless the item moves into the result register
    assign c_op_gated = advance ? c_op : '0;
    assign h_op_gated = advance ? h_op : '0;

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            outcome_reg      <= outcome_next;
            evict_valid_reg  <= evict_valid_next;
            evict_source_reg <= evict_source_next;
            evicted_key_reg  <= evicted_key_next;
            cache_fill_reg   <= c_count_next;
            history_fill_reg <= h_count_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_outcome      = outcome_reg;
    assign m_evict_valid  = evict_valid_reg;
    assign m_evict_source = evict_source_reg;
    assign m_evicted_key  = evicted_key_reg;
    assign m_cache_fill   = cache_fill_reg;
    assign m_history_fill = history_fill_reg;

endmodule
